FILE: rtl/core/calc_lex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package calc_lex_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int KIND_BITS   = 4;
  localparam int MODE_BITS   = 2;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [MODE_BITS-1:0]   mode_t;

  localparam offset_t POS_MAX = {OFFSET_BITS{1'b1}};

  localparam kind_t K_END    = 4'd0;
  localparam kind_t K_PLUS   = 4'd1;
  localparam kind_t K_MINUS  = 4'd2;
  localparam kind_t K_MULT   = 4'd3;
  localparam kind_t K_DIV    = 4'd4;
  localparam kind_t K_EQUAL  = 4'd5;
  localparam kind_t K_SEMI   = 4'd6;
  localparam kind_t K_LBR    = 4'd7;
  localparam kind_t K_RBR    = 4'd8;
  localparam kind_t K_NUMBER = 4'd9;
  localparam kind_t K_ID     = 4'd10;
  localparam kind_t K_ERROR  = 4'd11;

  localparam mode_t M_IDLE = 2'd0;
  localparam mode_t M_NUM  = 2'd1;
  localparam mode_t M_ID   = 2'd2;
  localparam mode_t M_ERR  = 2'd3;

  localparam logic [7:0] C_PLUS  = 8'h2B;
  localparam logic [7:0] C_MINUS = 8'h2D;
  localparam logic [7:0] C_MULT  = 8'h2A;
  localparam logic [7:0] C_DIV   = 8'h2F;
  localparam logic [7:0] C_EQUAL = 8'h3D;
  localparam logic [7:0] C_SEMI  = 8'h3B;
  localparam logic [7:0] C_LBR   = 8'h28;
  localparam logic [7:0] C_RBR   = 8'h29;
  localparam logic [7:0] C_DOT   = 8'h2E;
  localparam logic [7:0] C_UNDER = 8'h5F;
  localparam logic [7:0] C_ZERO  = 8'h30;
  localparam logic [7:0] C_NINE  = 8'h39;
  localparam logic [7:0] C_SPACE = 8'h20;
  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_CR    = 8'h0D;
  localparam logic [7:0] C_LC_A  = 8'h61;
  localparam logic [7:0] C_LC_Z  = 8'h7A;
  localparam logic [7:0] C_UC_A  = 8'h41;
  localparam logic [7:0] C_UC_Z  = 8'h5A;

  typedef struct packed {
    kind_t   kind;
    offset_t start;
    offset_t length;
    logic    last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= C_ZERO) && (c <= C_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= C_LC_A) && (c <= C_LC_Z)) || ((c >= C_UC_A) && (c <= C_UC_Z));
  endfunction

  function automatic logic is_idc(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == C_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == C_SPACE) || ((c >= C_TAB) && (c <= C_CR));
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      C_PLUS:  k = K_PLUS;
      C_MINUS: k = K_MINUS;
      C_MULT:  k = K_MULT;
      C_DIV:   k = K_DIV;
      C_EQUAL: k = K_EQUAL;
      C_SEMI:  k = K_SEMI;
      C_LBR:   k = K_LBR;
      C_RBR:   k = K_RBR;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/calculator_token_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer for calculator expressions. Each accepted transaction carries one
// text byte or the end mark; tokens come out as kind, start offset and length, with
// last set on the final token that a transaction causes. A byte is classified and
// the lexer state updated in the cycle it is accepted, so one byte is taken every
// cycle that input is not held off; a byte that closes a token and also forms a
// one-byte token gives two tokens, as does the end mark with a token open. Tokens
// wait in a four-entry result queue and input is held off only while fewer than
// two entries are free, so the sustained rate is one byte per cycle as long as the
// queue keeps two entries free. Offsets saturate at all ones; the end mark returns
// the lexer to offset zero.
module calculator_token_lexer (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [7:0]                         ch,
  input  wire                                end_of_text,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [calc_lex_pkg::KIND_BITS-1:0] kind,
  output logic [calc_lex_pkg::OFFSET_BITS-1:0] start_res,
  output logic [calc_lex_pkg::OFFSET_BITS-1:0] length,
  output logic                               last
);

  calc_lex_pkg::mode_t   mode, mode_next;
  calc_lex_pkg::offset_t position, position_next;
  calc_lex_pkg::offset_t token_start, token_start_next;
  logic number_valid, number_valid_next;
  logic seen_dot, seen_dot_next;
  logic prev_was_dot, prev_was_dot_next;
  logic head_was_zero, head_was_zero_next;

  calc_lex_pkg::token_t fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] cnt;

  calc_lex_pkg::token_t tok_close, tok_put, res0, res1;
  logic put_close, put_start;
  logic [1:0] n_res;
  logic in_fire, out_fire;
  logic c_digit, c_dot, c_idc;
  logic do_close, do_start;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (cnt > 3'd2);
  assign out_valid = (cnt != 3'd0);

  assign c_digit = calc_lex_pkg::is_digit(ch);
  assign c_dot   = (ch == calc_lex_pkg::C_DOT);
  assign c_idc   = calc_lex_pkg::is_idc(ch);

  always_comb begin
    mode_next          = mode;
    position_next      = position;
    token_start_next   = token_start;
    number_valid_next  = number_valid;
    seen_dot_next      = seen_dot;
    prev_was_dot_next  = prev_was_dot;
    head_was_zero_next = head_was_zero;
    do_close  = 1'b0;
    do_start  = 1'b0;
    put_close = 1'b0;
    put_start = 1'b0;

    tok_close.start  = token_start;
    tok_close.length = position - token_start;
    tok_close.last   = 1'b0;
    case (mode)
      calc_lex_pkg::M_NUM:
        tok_close.kind = (number_valid && !prev_was_dot) ? calc_lex_pkg::K_NUMBER
                                                         : calc_lex_pkg::K_ERROR;
      calc_lex_pkg::M_ID: tok_close.kind = calc_lex_pkg::K_ID;
      default:            tok_close.kind = calc_lex_pkg::K_ERROR;
    endcase

    tok_put.kind   = calc_lex_pkg::punct_kind(ch);
    tok_put.start  = position;
    tok_put.length = calc_lex_pkg::offset_t'(1);
    tok_put.last   = 1'b0;

    if (end_of_text) begin
      put_close      = (mode != calc_lex_pkg::M_IDLE);
      put_start      = 1'b1;
      tok_put.kind   = calc_lex_pkg::K_END;
      tok_put.length = '0;
      mode_next          = calc_lex_pkg::M_IDLE;
      position_next      = '0;
      token_start_next   = '0;
      number_valid_next  = 1'b0;
      seen_dot_next      = 1'b0;
      prev_was_dot_next  = 1'b0;
      head_was_zero_next = 1'b0;
    end else begin
      case (mode)
        calc_lex_pkg::M_NUM: begin
          if (c_digit || c_dot) begin
            if (head_was_zero && c_digit) number_valid_next = 1'b0;
            head_was_zero_next = 1'b0;
            if (c_dot) begin
              if (seen_dot) number_valid_next = 1'b0;
              seen_dot_next = 1'b1;
            end
            prev_was_dot_next = c_dot;
          end else if (c_idc) begin
            mode_next          = calc_lex_pkg::M_ERR;
            head_was_zero_next = 1'b0;
          end else begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        calc_lex_pkg::M_ID, calc_lex_pkg::M_ERR: begin
          if (!c_idc) begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      if (do_close) begin
        put_close          = 1'b1;
        mode_next          = calc_lex_pkg::M_IDLE;
        head_was_zero_next = 1'b0;
      end

      if (do_start && !calc_lex_pkg::is_space(ch)) begin
        if (tok_put.kind != calc_lex_pkg::K_ERROR) begin
          put_start = 1'b1;
        end else if (c_digit || c_dot) begin
          mode_next          = calc_lex_pkg::M_NUM;
          token_start_next   = position;
          number_valid_next  = c_digit;
          seen_dot_next      = 1'b0;
          prev_was_dot_next  = c_dot;
          head_was_zero_next = (ch == calc_lex_pkg::C_ZERO);
        end else if (c_idc) begin
          mode_next        = calc_lex_pkg::M_ID;
          token_start_next = position;
        end else begin
          put_start = 1'b1;
        end
      end

      if (position != calc_lex_pkg::POS_MAX) position_next = position + 1'b1;
    end

    res0      = put_close ? tok_close : tok_put;
    res0.last = !(put_close && put_start);
    res1      = tok_put;
    res1.last = 1'b1;
    n_res     = {1'b0, put_close} + {1'b0, put_start};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= calc_lex_pkg::M_IDLE;
      position      <= '0;
      token_start   <= '0;
      number_valid  <= 1'b0;
      seen_dot      <= 1'b0;
      prev_was_dot  <= 1'b0;
      head_was_zero <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      cnt           <= '0;
    end else begin
      if (in_fire) begin
        mode          <= mode_next;
        position      <= position_next;
        token_start   <= token_start_next;
        number_valid  <= number_valid_next;
        seen_dot      <= seen_dot_next;
        prev_was_dot  <= prev_was_dot_next;
        head_was_zero <= head_was_zero_next;
        wr_ptr        <= wr_ptr + n_res;
      end
      if (out_fire) rd_ptr <= rd_ptr + 2'd1;
      cnt <= cnt + (in_fire ? {1'b0, n_res} : 3'd0) - (out_fire ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (n_res != 2'd0)) fifo[wr_ptr] <= res0;
    if (in_fire && (n_res == 2'd2)) fifo[wr_ptr + 2'd1] <= res1;
  end

  assign kind      = fifo[rd_ptr].kind;
  assign start_res = fifo[rd_ptr].start;
  assign length    = fifo[rd_ptr].length;
  assign last      = fifo[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result queue overfilled");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_text |=> mode == calc_lex_pkg::M_IDLE && position == '0)
    else $error("end mark did not return lexer to start");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && !end_of_text && position != calc_lex_pkg::POS_MAX
    |=> position == $past(position) + 1'b1)
    else $error("offset did not advance");

endmodule

`default_nettype wire
